// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/dpsc_pkg.sv =====
// Package for the drum pad strike to command frame block.
// Holds widths, frame bytes, register indexes, types and shared functions.
package dpsc_pkg;

	localparam int PAD_COUNT  = 3;
	localparam int LANE_W     = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam int SAMPLE_W   = 10;
	localparam int VOL_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int CHK_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int POS_W      = 4;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_BND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOUD_BND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_VOL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_VOL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOUD_VOL   = 3'd5;

	localparam logic [SAMPLE_W-1:0] RST_THRESHOLD  = 10'd100;
	localparam logic [SAMPLE_W-1:0] RST_MEDIUM_BND = 10'd300;
	localparam logic [SAMPLE_W-1:0] RST_LOUD_BND   = 10'd600;
	localparam logic [VOL_W-1:0]    RST_SOFT_VOL   = 8'h14;
	localparam logic [VOL_W-1:0]    RST_MEDIUM_VOL = 8'h19;
	localparam logic [VOL_W-1:0]    RST_LOUD_VOL   = 8'h1E;

	localparam logic [BYTE_W-1:0] FRAME_START   = 8'h7E;
	localparam logic [BYTE_W-1:0] FRAME_VERSION = 8'hFF;
	localparam logic [BYTE_W-1:0] FRAME_LENGTH  = 8'h06;
	localparam logic [BYTE_W-1:0] FRAME_NO_ACK  = 8'h00;
	localparam logic [BYTE_W-1:0] FRAME_PARAM1  = 8'h00;
	localparam logic [BYTE_W-1:0] FRAME_END     = 8'hEF;
	localparam logic [BYTE_W-1:0] CMD_VOLUME    = 8'h06;
	localparam logic [BYTE_W-1:0] CMD_PLAY      = 8'h03;

	localparam logic [POS_W-1:0] POS_START   = 4'd0;
	localparam logic [POS_W-1:0] POS_VERSION = 4'd1;
	localparam logic [POS_W-1:0] POS_LENGTH  = 4'd2;
	localparam logic [POS_W-1:0] POS_CMD     = 4'd3;
	localparam logic [POS_W-1:0] POS_ACK     = 4'd4;
	localparam logic [POS_W-1:0] POS_P1      = 4'd5;
	localparam logic [POS_W-1:0] POS_P2      = 4'd6;
	localparam logic [POS_W-1:0] POS_CHK_HI  = 4'd7;
	localparam logic [POS_W-1:0] POS_CHK_LO  = 4'd8;
	localparam logic [POS_W-1:0] POS_END     = 4'd9;

	localparam logic [BYTE_W-1:0] TRACK_OF_PAD [3] = '{8'd3, 8'd1, 8'd2};

	typedef struct packed {
		logic [SAMPLE_W-1:0] threshold;
		logic [SAMPLE_W-1:0] medium_bound;
		logic [SAMPLE_W-1:0] loud_bound;
		logic [VOL_W-1:0]    soft_volume;
		logic [VOL_W-1:0]    medium_volume;
		logic [VOL_W-1:0]    loud_volume;
	} cfg_t;

	typedef struct packed {
		logic             strike;
		logic [VOL_W-1:0] vol;
	} lane_res_t;

	function automatic logic [CHK_W-1:0] frame_checksum(input logic [BYTE_W-1:0] cmd,
		input logic [BYTE_W-1:0] p2);
		logic [CHK_W-1:0] sum;
		sum = CHK_W'(FRAME_VERSION) + CHK_W'(FRAME_LENGTH) + CHK_W'(cmd)
			+ CHK_W'(FRAME_NO_ACK) + CHK_W'(FRAME_PARAM1) + CHK_W'(p2);
		return CHK_W'(0) - sum;
	endfunction

	function automatic logic [LANE_W-1:0] top_lane(input logic [PAD_COUNT-1:0] mask);
		logic [LANE_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < PAD_COUNT; i++) begin
			if (mask[i]) begin
				idx = LANE_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/dpsc_lane.sv =====
// One pad lane: keeps the previous sample, detects a rising crossing
// and picks the volume byte. Depends on dpsc_pkg.
module dpsc_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [dpsc_pkg::SAMPLE_W-1:0] sample,
	input  dpsc_pkg::cfg_t                cfg,
	output dpsc_pkg::lane_res_t           res
);
	import dpsc_pkg::*;

	logic [SAMPLE_W-1:0] prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= sample;
		end
	end

	always_comb begin
		res.strike = (sample > cfg.threshold) && (prev_q <= cfg.threshold);
		if (sample < cfg.medium_bound) begin
			res.vol = cfg.soft_volume;
		end else if (sample < cfg.loud_bound) begin
			res.vol = cfg.medium_volume;
		end else begin
			res.vol = cfg.loud_volume;
		end
	end

endmodule

// ===== rtl/dpsc_ser.sv =====
// Merge stage: walks the struck lanes from the highest channel down and
// sends two command frames per strike, one byte per word. Depends on dpsc_pkg.
module dpsc_ser (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      load_valid,
	input  dpsc_pkg::lane_res_t [dpsc_pkg::PAD_COUNT-1:0] load,
	output logic                                      take,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [dpsc_pkg::BYTE_W-1:0]               frame_byte,
	output logic                                      last_of_run
);
	import dpsc_pkg::*;

	logic [PAD_COUNT-1:0] pend_q;
	logic [VOL_W-1:0]     vols_q [PAD_COUNT];
	logic                 play_q;
	logic [POS_W-1:0]     pos_q;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 last_q;

	logic [PAD_COUNT-1:0] strikes;
	logic [LANE_W-1:0]    cur;
	logic [BYTE_W-1:0]    cmd;
	logic [BYTE_W-1:0]    p2;
	logic [CHK_W-1:0]     chk;
	logic [BYTE_W-1:0]    next_byte;
	logic                 frame_done;
	logic                 run_last;
	logic                 emit;

	always_comb begin
		for (int i = 0; i < PAD_COUNT; i++) begin
			strikes[i] = load[i].strike;
		end
	end

	assign cur        = top_lane(pend_q);
	assign cmd        = play_q ? CMD_PLAY : CMD_VOLUME;
	assign p2         = play_q ? TRACK_OF_PAD[cur] : vols_q[cur];
	assign chk        = frame_checksum(cmd, p2);
	assign frame_done = (pos_q == POS_END);
	assign run_last   = frame_done && play_q && ((pend_q & (pend_q - 1'b1)) == '0);
	assign emit       = (pend_q != '0) && (!out_valid_q || !out_stall);
	assign take       = load_valid && (pend_q == '0);

	always_comb begin
		unique case (pos_q)
			POS_START:   next_byte = FRAME_START;
			POS_VERSION: next_byte = FRAME_VERSION;
			POS_LENGTH:  next_byte = FRAME_LENGTH;
			POS_CMD:     next_byte = cmd;
			POS_ACK:     next_byte = FRAME_NO_ACK;
			POS_P1:      next_byte = FRAME_PARAM1;
			POS_P2:      next_byte = p2;
			POS_CHK_HI:  next_byte = chk[CHK_W-1:BYTE_W];
			POS_CHK_LO:  next_byte = chk[BYTE_W-1:0];
			POS_END:     next_byte = FRAME_END;
			default:     next_byte = FRAME_END;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			play_q <= 1'b0;
			pos_q  <= POS_START;
		end else if (take) begin
			pend_q <= strikes;
			play_q <= 1'b0;
			pos_q  <= POS_START;
		end else if (emit) begin
			if (frame_done) begin
				pos_q  <= POS_START;
				play_q <= !play_q;
				if (play_q) begin
					pend_q[cur] <= 1'b0;
				end
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < PAD_COUNT; i++) begin
				vols_q[i] <= load[i].vol;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= next_byte;
			last_q <= run_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_byte  = byte_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/drum_pad_strike_to_command_frames.sv =====
// Top level: pad lanes, a scan register and the frame merge stage.
// Depends on dpsc_pkg, dpsc_lane and dpsc_ser.
// A scan's first byte passes the scan register and the merge stage's pending lanes
// before the output register. Output: one byte per cycle while out_stall is low,
// 20 bytes per strike; a new scan can wait in the scan register meanwhile.
// Reset at once sets default config, clears old samples, valid flags, pending work.
module drum_pad_strike_to_command_frames (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dpsc_pkg::SAMPLE_W-1:0]   sample_ch0,
	input  logic [dpsc_pkg::SAMPLE_W-1:0]   sample_ch1,
	input  logic [dpsc_pkg::SAMPLE_W-1:0]   sample_ch2,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dpsc_pkg::BYTE_W-1:0]     frame_byte,
	output logic                            last_of_run,
	input  logic                            cfg_we,
	input  logic [dpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpsc_pkg::*;

	cfg_t                            cfg_q;
	logic [SAMPLE_W-1:0]             samples [3];
	lane_res_t [PAD_COUNT-1:0]       lane_res;
	lane_res_t [PAD_COUNT-1:0]       lane_s1;
	logic                            s1_valid_q;
	logic                            accept;
	logic                            take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= RST_THRESHOLD;
			cfg_q.medium_bound  <= RST_MEDIUM_BND;
			cfg_q.loud_bound    <= RST_LOUD_BND;
			cfg_q.soft_volume   <= RST_SOFT_VOL;
			cfg_q.medium_volume <= RST_MEDIUM_VOL;
			cfg_q.loud_volume   <= RST_LOUD_VOL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:  cfg_q.threshold     <= cfg_data;
				REG_MEDIUM_BND: cfg_q.medium_bound  <= cfg_data;
				REG_LOUD_BND:   cfg_q.loud_bound    <= cfg_data;
				REG_SOFT_VOL:   cfg_q.soft_volume   <= cfg_data[VOL_W-1:0];
				REG_MEDIUM_VOL: cfg_q.medium_volume <= cfg_data[VOL_W-1:0];
				REG_LOUD_VOL:   cfg_q.loud_volume   <= cfg_data[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign samples[0] = sample_ch0;
	assign samples[1] = sample_ch1;
	assign samples[2] = sample_ch2;

	assign in_stall = s1_valid_q && !take;
	assign accept   = in_valid && !in_stall;

	for (genvar g = 0; g < PAD_COUNT; g++) begin : g_lane
		dpsc_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.accept (accept),
			.sample (samples[g]),
			.cfg    (cfg_q),
			.res    (lane_res[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lane_s1 <= lane_res;
		end
	end

	dpsc_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load_valid  (s1_valid_q),
		.load        (lane_s1),
		.take        (take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.last_of_run (last_of_run)
	);

endmodule

// ===== rtl/dpsc_chk.sv =====
// Port checker for the drum pad strike block, bound to the top level.
// Depends on dpsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dpsc_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [dpsc_pkg::BYTE_W-1:0] frame_byte,
	input logic                        last_of_run
);
	import dpsc_pkg::*;

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(last_of_run), "stalled output word changed")
	`ASSERT_CLK(a_last_is_end, clk, arst_n, out_valid && last_of_run |-> frame_byte == FRAME_END, "last word of a run is not a frame end")
	`ASSERT_CLK(a_stall_after_accept, clk, arst_n, $rose(in_stall) |-> $past(in_valid), "input stall rose without a prior input word")
	`ASSERT_NEVER(a_no_stall_in_reset_exit, clk, arst_n, in_stall && !$past(arst_n), "input stalled right after reset")

endmodule

bind drum_pad_strike_to_command_frames dpsc_chk u_dpsc_chk (.*);
